[sv/scaled_rgba4444_alpha_blit_core_assert.svh]
// Assertion macros shared by the blitter modules.
`ifndef SCALED_RGBA4444_ALPHA_BLIT_CORE_ASSERT_SVH
`define SCALED_RGBA4444_ALPHA_BLIT_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SRAB_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Implication with the consequent checked in the following cycle.
`define SRAB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

[sv/srab_pkg.sv]
package srab_pkg;
  localparam int SrcMax = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_BLEND,
    ST_OUT
  } srab_state_t;

  typedef enum logic [2:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_DEST_WIDTH  = 3'd2,
    REG_DEST_HEIGHT = 3'd3,
    REG_SRC_WIDTH   = 3'd4,
    REG_SRC_HEIGHT  = 3'd5,
    REG_DIM_LEVEL   = 3'd6
  } srab_reg_t;

  typedef struct packed {
    logic load;       // capture input beat
    logic div_start;  // start both coordinate dividers
    logic calc_addr;  // register whether the texel address is in range
    logic mul;        // register color and dim products
    logic blend;      // register blend results
    logic out_load;   // fill output register and step counters
  } srab_cmd_t;

  typedef struct packed {
    logic is_blend;
    logic div_done;
  } srab_status_t;

  localparam int AddrW = 12;
  localparam int DataW = 16;

  typedef struct packed {
    logic [AddrW-1:0] index;
    logic [31:0]      data;
  } srab_cfg_beat_t;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] texel_index;
    logic [DataW-1:0] texel_value;
    logic [7:0]       dest_red;
    logic [7:0]       dest_green;
    logic [7:0]       dest_blue;
  } srab_in_beat_t;

  typedef struct packed {
    logic       write_enable;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       rect_done;
  } srab_out_beat_t;

  // Exact floor(x/255) for x < 65280.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] q;
    logic [24:0] p;
    begin
      p = 25'(x) * 25'd257;
      q = 17'((p + 25'd257) >> 16);
      div255 = q[7:0];
    end
  endfunction
endpackage

[sv/srab_if.sv]
interface srab_in_if;
  import srab_pkg::*;
  logic          valid;
  logic          ready;
  srab_in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srab_out_if;
  import srab_pkg::*;
  logic           valid;
  logic           ready;
  srab_out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srab_cfg_if;
  import srab_pkg::*;
  logic           valid;
  logic           ready;
  srab_cfg_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/srab_ram.sv]
module srab_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/srab_div.sv]
// Restoring divider, one quotient bit per cycle: num / den, 16-bit num.
module srab_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [8:0]  den,
  output logic [15:0] quo,
  output logic        done
);
  logic [15:0] q;
  logic [9:0]  rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [9:0]  trial;

  assign trial = {rem[8:0], q[15]};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        q    <= num;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q   <= {q[14:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[sv/srab_ctrl.sv]
module srab_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  srab_pkg::srab_status_t status,
  output logic                 in_ready,
  output srab_pkg::srab_cmd_t  cmd
);
  import srab_pkg::*;
  `include "scaled_rgba4444_alpha_blit_core_assert.svh"

  srab_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.is_blend) begin
            state_next = ST_DIV;
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.calc_addr = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.blend = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SRAB_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == ST_IDLE)
  `SRAB_ASSERT_NEXT(a_div_go, clk, rst, cmd.div_start, state == ST_DIV)
  `SRAB_ASSERT_NEXT(a_out_back, clk, rst, cmd.out_load, state == ST_IDLE)
endmodule

[sv/srab_dp.sv]
module srab_dp #(
  parameter int ScreenW  = 400,
  parameter int ScreenH  = 240,
  parameter int MaxTexels = 4096,
  parameter int MaxRect  = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srab_pkg::srab_cmd_t     cmd,
  output srab_pkg::srab_status_t  status,
  input  srab_pkg::srab_in_beat_t in_beat,
  input  logic                    cfg_we,
  input  srab_pkg::srab_cfg_beat_t cfg_beat,
  input  logic                    out_take,
  output logic                    out_valid,
  output srab_pkg::srab_out_beat_t out_beat
);
  import srab_pkg::*;
  `include "scaled_rgba4444_alpha_blit_core_assert.svh"

  localparam int TAW = $clog2(MaxTexels);

  // configuration
  logic [10:0] dest_x, dest_y;
  logic [8:0]  dest_width, dest_height;
  logic [6:0]  src_width, src_height;
  logic [7:0]  dim_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x <= '0; dest_y <= '0;
      dest_width <= 9'd16; dest_height <= 9'd16;
      src_width <= 7'd16; src_height <= 7'd16;
      dim_level <= '0;
    end else if (cfg_we) begin
      case (cfg_beat.index)
        12'(REG_DEST_X):      dest_x      <= cfg_beat.data[10:0];
        12'(REG_DEST_Y):      dest_y      <= cfg_beat.data[10:0];
        12'(REG_DEST_WIDTH):  dest_width  <= cfg_beat.data[8:0];
        12'(REG_DEST_HEIGHT): dest_height <= cfg_beat.data[8:0];
        12'(REG_SRC_WIDTH):   src_width   <= cfg_beat.data[6:0];
        12'(REG_SRC_HEIGHT):  src_height  <= cfg_beat.data[6:0];
        12'(REG_DIM_LEVEL):   dim_level   <= cfg_beat.data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] hi);
    if (v == '0) return 9'd1;
    return (v > hi) ? hi : v;
  endfunction
  function automatic logic [6:0] clamp7(input logic [6:0] v);
    if (v == '0) return 7'd1;
    return (v > 7'(SrcMax)) ? 7'(SrcMax) : v;
  endfunction

  logic [8:0] dw, dh;
  logic [6:0] sw, sh;
  assign dw = clamp9(dest_width, 9'(MaxRect));
  assign dh = clamp9(dest_height, 9'(MaxRect));
  assign sw = clamp7(src_width);
  assign sh = clamp7(src_height);

  // counters and captured beat
  logic [7:0] col, row;
  srab_in_beat_t ib;

  always_ff @(posedge clk) begin
    if (cmd.load) ib <= in_beat;
  end

  logic last_col, done_flag;
  assign last_col  = ({1'b0, col} + 9'd1) >= dw;
  assign done_flag = last_col && (({1'b0, row} + 9'd1) >= dh);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0;
    end else if (cmd.out_load) begin
      if (done_flag) begin
        col <= '0; row <= '0;
      end else if (last_col) begin
        col <= '0; row <= row + 8'd1;
      end else begin
        col <= col + 8'd1;
      end
    end
  end

  // coordinate dividers
  logic [15:0] qx, qy;
  logic dx_done, dy_done;
  srab_div u_divx (.clk, .rst, .start(cmd.div_start),
    .num(16'(col) * 16'(sw)), .den(dw), .quo(qx), .done(dx_done));
  srab_div u_divy (.clk, .rst, .start(cmd.div_start),
    .num(16'(row) * 16'(sh)), .den(dh), .quo(qy), .done(dy_done));

  assign status.is_blend = in_beat.action;
  assign status.div_done = dx_done & dy_done;

  logic [6:0]  sx, sy;
  logic [12:0] addr_full;
  logic        addr_ok;
  logic        addr_ok_q;
  assign sx = (qx >= 16'(sw)) ? sw - 7'd1 : qx[6:0];
  assign sy = (qy >= 16'(sh)) ? sh - 7'd1 : qy[6:0];
  assign addr_full = 13'(sy) * 13'(sw) + 13'(sx);
  assign addr_ok = addr_full < 13'(MaxTexels);

  logic [DataW-1:0] rdata;
  logic load_we;
  assign load_we = cmd.load && !in_beat.action && (13'(in_beat.texel_index) < 13'(MaxTexels));

  srab_ram #(.Width(DataW), .Depth(MaxTexels)) u_ram (
    .clk, .we(load_we), .waddr(in_beat.texel_index[TAW-1:0]),
    .wdata(in_beat.texel_value), .raddr(addr_full[TAW-1:0]), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (cmd.calc_addr) addr_ok_q <= addr_ok;
  end

  // color stage
  logic [15:0] tex;
  logic [7:0]  a8, r8, g8, b8;
  logic [7:0]  rd, gd, bd;
  logic [7:0]  a_q, r_q, g_q, b_q;
  assign tex = addr_ok_q ? rdata : '0;
  assign a8 = 8'(tex[3:0] * 8'd17);
  assign r8 = 8'(tex[15:12] * 8'd17);
  assign g8 = 8'(tex[11:8] * 8'd17);
  assign b8 = 8'(tex[7:4] * 8'd17);
  assign rd = (dim_level != 0) ? div255(16'(r8) * 16'(8'd255 - dim_level)) : r8;
  assign gd = (dim_level != 0) ? div255(16'(g8) * 16'(8'd255 - dim_level)) : g8;
  assign bd = (dim_level != 0) ? div255(16'(b8) * 16'(8'd255 - dim_level)) : b8;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      a_q <= a8; r_q <= rd; g_q <= gd; b_q <= bd;
    end
  end

  function automatic logic [7:0] blend(input logic [7:0] d, input logic [7:0] s,
                                       input logic [7:0] a);
    return div255(16'(d) * 16'(8'd255 - a) + 16'(s) * 16'(a));
  endfunction

  logic [7:0] br, bg, bb;
  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      br <= blend(ib.dest_red, r_q, a_q);
      bg <= blend(ib.dest_green, g_q, a_q);
      bb <= blend(ib.dest_blue, b_q, a_q);
    end
  end

  logic signed [11:0] sxp, syp;
  logic we;
  assign sxp = $signed({dest_x[10], dest_x}) + $signed({4'b0, col});
  assign syp = $signed({dest_y[10], dest_y}) + $signed({4'b0, row});
  assign we = (a_q != 0) && !sxp[11] && (sxp < 12'sd0 + 12'(ScreenW))
              && !syp[11] && (syp < 12'sd0 + 12'(ScreenH));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat.write_enable <= we;
      out_beat.pixel_x   <= we ? sxp[9:0] : '0;
      out_beat.pixel_y   <= we ? syp[9:0] : '0;
      out_beat.out_red   <= we ? br : '0;
      out_beat.out_green <= we ? bg : '0;
      out_beat.out_blue  <= we ? bb : '0;
      out_beat.rect_done <= done_flag;
    end
  end

  `SRAB_ASSERT_IMP(a_no_overrun, clk, rst, cmd.out_load, !out_valid || out_take)
  `SRAB_ASSERT_IMP(a_div_pair, clk, rst, dx_done, dy_done)
  `SRAB_ASSERT_NEXT(a_wrap, clk, rst, cmd.out_load && done_flag, col == '0 && row == '0)
endmodule

[sv/scaled_rgba4444_alpha_blit_core.sv]
// Scaled RGBA4444 sprite blitter. Load beats (action 0) write one texel into
// the sprite RAM. Blend beats (action 1) supply the current framebuffer pixel
// of the destination rectangle in raster order and return one result beat:
// nearest-neighbour texel, optional dimming, alpha blend over the framebuffer
// color. A blend beat passes through the two bit-serial coordinate dividers,
// which run side by side, then address and RAM read, read data, multiply,
// blend and the output register. One beat is in flight at a time. The
// controller goes back to idle as soon as the result is loaded into the
// output register, so the next beat may be accepted the following cycle,
// while that result still waits for the sink. A result that is still waiting
// holds the next one in its output stage until the sink takes it. The user
// must see that configuration is written only while idle; the block does not
// enforce it.
module scaled_rgba4444_alpha_blit_core #(
  parameter int SCREEN_W   = 400,
  parameter int SCREEN_H   = 240,
  parameter int MAX_TEXELS = 4096,
  parameter int MAX_RECT   = 256
) (
  input logic       clk,
  input logic       rst,
  srab_cfg_if.sink  cfg,
  srab_in_if.sink   in_ch,
  srab_out_if.source out_ch
);
  import srab_pkg::*;

  srab_cmd_t    cmd;
  srab_status_t status;
  logic         out_valid;

  // config is always taken
  assign cfg.ready = 1'b1;

  srab_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid),
    .out_free(!out_valid || out_ch.ready),
    .status, .in_ready(in_ch.ready), .cmd);

  srab_dp #(.ScreenW(SCREEN_W), .ScreenH(SCREEN_H),
            .MaxTexels(MAX_TEXELS), .MaxRect(MAX_RECT)) u_dp (
    .clk, .rst, .cmd, .status,
    .in_beat(in_ch.payload),
    .cfg_we(cfg.valid), .cfg_beat(cfg.payload),
    .out_take(out_ch.ready), .out_valid, .out_beat(out_ch.payload));

  assign out_ch.valid = out_valid;
endmodule
